// ===== rtl/spq_pkg.sv =====
// Package for the sortable process queue: sizes, command codes, status codes,
// and the controller state type. No dependencies.
package spq_pkg;
  localparam int Depth = 16;
  localparam int SlotW = $clog2(Depth);
  localparam int CountW = $clog2(Depth + 1);

  typedef enum logic [2:0] {
    FN_PUSH_REAR = 3'd0,
    FN_PUSH_FRONT = 3'd1,
    FN_POP = 3'd2,
    FN_SORT_BURST = 3'd3,
    FN_SORT_PRIO_UP = 3'd4,
    FN_SORT_PRIO_DN = 3'd5
  } func_t;

  typedef enum logic [1:0] {
    ST_OK = 2'd0,
    ST_EMPTY = 2'd1,
    ST_FULL = 2'd2
  } status_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_POP_RD,
    S_LOAD,
    S_CMP_RD,
    S_CMP,
    S_OUT
  } state_t;
endpackage

// ===== rtl/sortable_process_queue_top.sv =====
// Top level of the sortable process queue: key and time memories plus the
// controller that pushes, pops and insertion-sorts them. Uses spq_pkg.
//
// Channel | direction | tdata fields (low bit first)          | tuser
// s_axis  | in        | func, id, burst, prio, start, finish   | -
// m_axis  | out       | valid, id, burst, prio, start, finish, | -
//         |           | is_empty, entry_total, status          |
//
// A push writes the memories when it is accepted and goes to S_OUT; a pop
// first reads the front record in S_POP_RD. A sort takes each record i in turn
// (S_LOAD), compares it with the record below it (S_CMP) and, after each shift,
// reads the next one down in S_CMP_RD, since the two memories have a registered
// read; a record that reaches the front is written there from S_CMP_RD.
// Reset empties the queue; memory contents are left as they are.
// A result waits in the output register; a new request is taken once it
// has been taken.
module sortable_process_queue_top (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // func[2:0] id[10:3] burst[26:11] prio[34:27] start[50:35] finish[66:51]
  input  logic [71:0] s_axis_tdata,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // valid[0] id[8:1] burst[24:9] prio[32:25] start[48:33] finish[64:49]
  // is_empty[65] entry_total[70:66] status[72:71]
  output logic [79:0] m_axis_tdata
);
  localparam int SW = spq_pkg::SlotW;
  localparam int CW = spq_pkg::CountW;

  logic [31:0] key_mem [spq_pkg::Depth];
  logic [31:0] time_mem [spq_pkg::Depth];

  spq_pkg::state_t state, state_next;
  logic [SW-1:0] head, head_next;
  logic [CW-1:0] count, count_next;
  logic [2:0] func;
  logic [31:0] in_kw, in_tw;
  logic [CW-1:0] idx_i, idx_j;
  logic [31:0] cur_kw, cur_tw;
  logic [31:0] rd_kw, rd_tw;
  logic [SW-1:0] rd_addr;
  logic we;
  logic [SW-1:0] wr_addr;
  logic [31:0] wr_kw, wr_tw;
  logic out_valid;
  logic [79:0] out_data;

  // Memories: one write and one registered read per cycle.
  always_ff @(posedge clk) begin
    if (we) begin
      key_mem[wr_addr] <= wr_kw;
      time_mem[wr_addr] <= wr_tw;
    end
    rd_kw <= key_mem[rd_addr];
    rd_tw <= time_mem[rd_addr];
  end

  function automatic logic [SW-1:0] slot(input logic [SW-1:0] h, input logic [CW-1:0] p);
    logic [CW:0] s;
    s = {1'b0, {(CW - SW){1'b0}}, h} + {1'b0, p};
    return s[SW-1:0];
  endfunction

  function automatic logic after(input logic [31:0] a, input logic [31:0] b,
                                 input logic [2:0] m);
    logic after_r;
    if (m == spq_pkg::FN_SORT_BURST) after_r = a[23:8] > b[23:8];
    else if (m == spq_pkg::FN_SORT_PRIO_DN) after_r = a[7:0] < b[7:0];
    else after_r = a[7:0] > b[7:0];
    return after_r;
  endfunction

  logic [CW-1:0] jm1;
  logic accept;
  assign jm1 = idx_j - CW'(1);
  assign s_axis_tready = (state == spq_pkg::S_IDLE) && !out_valid;
  assign accept = s_axis_tvalid && s_axis_tready;
  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata = out_data;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= spq_pkg::S_IDLE;
      head <= '0;
      count <= '0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      head <= head_next;
      count <= count_next;
      if (state_next == spq_pkg::S_OUT) out_valid <= 1'b1;
      else if (m_axis_tready) out_valid <= 1'b0;
    end
  end

  logic [79:0] data_next;
  logic [CW-1:0] i_next, j_next;
  logic [31:0] ck_next, ct_next;

  always_ff @(posedge clk) begin
    if (accept) begin
      func <= s_axis_tdata[2:0];
      in_kw <= {s_axis_tdata[10:3], s_axis_tdata[26:11], s_axis_tdata[34:27]};
      in_tw <= {s_axis_tdata[50:35], s_axis_tdata[66:51]};
    end
    idx_i <= i_next;
    idx_j <= j_next;
    cur_kw <= ck_next;
    cur_tw <= ct_next;
    out_data <= data_next;
  end

  always_comb begin
    state_next = state;
    head_next = head;
    count_next = count;
    i_next = idx_i;
    j_next = idx_j;
    ck_next = cur_kw;
    ct_next = cur_tw;
    data_next = out_data;
    rd_addr = head;
    we = 1'b0;
    wr_addr = head;
    wr_kw = in_kw;
    wr_tw = in_tw;
    case (state)
      spq_pkg::S_IDLE: begin
        if (accept) begin
          data_next = '0;
          case (s_axis_tdata[2:0])
            spq_pkg::FN_PUSH_REAR, spq_pkg::FN_PUSH_FRONT: begin
              if (count >= CW'(spq_pkg::Depth)) data_next[72:71] = spq_pkg::ST_FULL;
              else if (s_axis_tdata[2:0] == spq_pkg::FN_PUSH_REAR) begin
                wr_addr = slot(head, count);
              end else begin
                wr_addr = head - SW'(1);
                head_next = wr_addr;
              end
              if (count < CW'(spq_pkg::Depth)) begin
                we = 1'b1;
                wr_kw = {s_axis_tdata[10:3], s_axis_tdata[26:11], s_axis_tdata[34:27]};
                wr_tw = {s_axis_tdata[50:35], s_axis_tdata[66:51]};
                count_next = count + CW'(1);
              end
              state_next = spq_pkg::S_OUT;
            end
            spq_pkg::FN_POP: begin
              if (count == '0) begin
                data_next[72:71] = spq_pkg::ST_EMPTY;
                state_next = spq_pkg::S_OUT;
              end else state_next = spq_pkg::S_POP_RD;
            end
            spq_pkg::FN_SORT_BURST, spq_pkg::FN_SORT_PRIO_UP,
            spq_pkg::FN_SORT_PRIO_DN: begin
              i_next = CW'(1);
              rd_addr = slot(head, CW'(1));
              state_next = (count > CW'(1)) ? spq_pkg::S_LOAD : spq_pkg::S_OUT;
            end
            default: state_next = spq_pkg::S_OUT;
          endcase
        end
      end
      spq_pkg::S_POP_RD: begin
        data_next = '0;
        data_next[0] = 1'b1;
        data_next[8:1] = rd_kw[31:24];
        data_next[24:9] = rd_kw[23:8];
        data_next[32:25] = rd_kw[7:0];
        data_next[48:33] = rd_tw[31:16];
        data_next[64:49] = rd_tw[15:0];
        head_next = head + SW'(1);
        count_next = count - CW'(1);
        state_next = spq_pkg::S_OUT;
      end
      spq_pkg::S_LOAD: begin
        // Record i has been read; start comparing it with position i-1.
        ck_next = rd_kw;
        ct_next = rd_tw;
        j_next = idx_i;
        rd_addr = slot(head, idx_i - CW'(1));
        state_next = spq_pkg::S_CMP;
      end
      spq_pkg::S_CMP_RD: begin
        rd_addr = slot(head, jm1);
        state_next = spq_pkg::S_CMP;
      end
      spq_pkg::S_CMP: begin
        we = 1'b1;
        wr_addr = slot(head, idx_j);
        if (after(rd_kw, cur_kw, func)) begin
          // Shift the record at j-1 up one place and keep walking down.
          wr_kw = rd_kw;
          wr_tw = rd_tw;
          j_next = jm1;
          if (jm1 == '0) begin
            state_next = spq_pkg::S_CMP;
            // Place at position 0 next cycle through the same write path.
            state_next = spq_pkg::S_CMP_RD;
          end else state_next = spq_pkg::S_CMP_RD;
        end else begin
          wr_kw = cur_kw;
          wr_tw = cur_tw;
          i_next = idx_i + CW'(1);
          rd_addr = slot(head, idx_i + CW'(1));
          state_next = (idx_i + CW'(1) < count) ? spq_pkg::S_LOAD : spq_pkg::S_OUT;
        end
        if (after(rd_kw, cur_kw, func) && jm1 == '0) begin
          // Nothing left below: the next cycle writes the held record at 0.
          state_next = spq_pkg::S_CMP_RD;
        end
      end
      spq_pkg::S_OUT: begin
        state_next = spq_pkg::S_IDLE;
      end
      default: state_next = spq_pkg::S_IDLE;
    endcase
    if (state == spq_pkg::S_CMP_RD && idx_j == '0) begin
      // Insertion point is the front: write the held record there.
      we = 1'b1;
      wr_addr = head;
      wr_kw = cur_kw;
      wr_tw = cur_tw;
      i_next = idx_i + CW'(1);
      rd_addr = slot(head, idx_i + CW'(1));
      state_next = (idx_i + CW'(1) < count) ? spq_pkg::S_LOAD : spq_pkg::S_OUT;
    end
    if (state_next == spq_pkg::S_OUT) begin
      data_next[65] = (count_next == '0);
      data_next[70:66] = 5'(count_next);
    end
  end
endmodule

// ===== rtl/spq_checker.sv =====
// Port-level checker for the sortable process queue, bound to the top level.
// Depends on sortable_process_queue_top ports only.
module spq_checker (
  input logic        clk,
  input logic        rst,
  input logic        s_axis_tvalid,
  input logic        s_axis_tready,
  input logic [71:0] s_axis_tdata,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [79:0] m_axis_tdata
);
  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("result changed while stalled");
  a_empty: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> m_axis_tdata[65] == (m_axis_tdata[70:66] == 5'd0))
    else $error("empty flag disagrees with count");
  a_max: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> m_axis_tdata[70:66] <= 5'd16)
    else $error("count above depth");
  a_pop_status: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && m_axis_tdata[0] |-> m_axis_tdata[72:71] == 2'd0)
    else $error("popped record with error status");
endmodule

bind sortable_process_queue_top spq_checker u_spq_checker (.*);

// ===== tb/sortable_process_queue_top_test.sv =====
// Self-checking testbench for the sortable process queue: drives push, pop and
// sort requests on the input stream and compares every result with a predictor.
// Depends on spq_pkg and sortable_process_queue_top.
module sortable_process_queue_top_test;
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic [2:0]  func;
    logic [7:0]  pid;
    logic [15:0] burst;
    logic [7:0]  prio;
    logic [15:0] start;
    logic [15:0] finish;
  } request_t;

  // Members run from the top bit down, so status sits highest as on m_axis_tdata.
  typedef struct packed {
    logic [1:0]  status;
    logic [4:0]  total;
    logic        empty;
    logic [15:0] finish;
    logic [15:0] start;
    logic [7:0]  prio;
    logic [15:0] burst;
    logic [7:0]  pid;
    logic        valid;
  } outcome_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [71:0] s_axis_tdata = '0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [79:0] m_axis_tdata;

  sortable_process_queue_top DUT (.*);

  always #5 clk = ~clk;

  // Predictor state: records kept in queue order, front first.
  request_t queue_model[$];
  outcome_t expected_outcomes[$];
  int mismatches = 0;
  int requests_sent = 0;
  int records_popped = 0;
  int sorts_sent = 0;
  int overflows = 0;
  int underflows = 0;
  bit hold_off = 1'b0;

  function automatic bit sorts_after(request_t a, request_t b, logic [2:0] mode);
    if (mode == spq_pkg::FN_SORT_BURST) return a.burst > b.burst;
    if (mode == spq_pkg::FN_SORT_PRIO_DN) return a.prio < b.prio;
    return a.prio > b.prio;
  endfunction

  function automatic outcome_t apply_request(request_t r);
    outcome_t o;
    request_t rec;
    request_t held;
    int j;
    o = '0;
    rec = r;
    rec.func = '0;
    case (r.func)
      spq_pkg::FN_PUSH_REAR, spq_pkg::FN_PUSH_FRONT: begin
        if (queue_model.size() >= spq_pkg::Depth) begin
          o.status = spq_pkg::ST_FULL;
        end else if (r.func == spq_pkg::FN_PUSH_REAR) begin
          queue_model.push_back(rec);
        end else begin
          queue_model.push_front(rec);
        end
      end
      spq_pkg::FN_POP: begin
        if (queue_model.size() == 0) begin
          o.status = spq_pkg::ST_EMPTY;
        end else begin
          held = queue_model.pop_front();
          o.valid = 1'b1;
          o.pid = held.pid;
          o.burst = held.burst;
          o.prio = held.prio;
          o.start = held.start;
          o.finish = held.finish;
        end
      end
      spq_pkg::FN_SORT_BURST, spq_pkg::FN_SORT_PRIO_UP, spq_pkg::FN_SORT_PRIO_DN: begin
        for (int i = 1; i < queue_model.size(); i++) begin
          held = queue_model[i];
          j = i;
          while (j > 0 && sorts_after(queue_model[j-1], held, r.func)) begin
            queue_model[j] = queue_model[j-1];
            j--;
          end
          queue_model[j] = held;
        end
      end
      default: ;
    endcase
    o.empty = (queue_model.size() == 0);
    o.total = 5'(queue_model.size());
    return o;
  endfunction

  // Valid stays high between back-to-back requests; it drops only for a gap.
  task automatic send_request(request_t r, int gap);
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    s_axis_tdata <= {5'd0, r.finish, r.start, r.prio, r.burst, r.pid, r.func};
    s_axis_tvalid <= 1'b1;
    do @(posedge clk); while (!s_axis_tready);
    expected_outcomes.push_back(apply_request(r));
    requests_sent++;
    if (r.func == spq_pkg::FN_POP && expected_outcomes[$].valid) records_popped++;
    if (r.func >= spq_pkg::FN_SORT_BURST && r.func <= spq_pkg::FN_SORT_PRIO_DN)
      sorts_sent++;
    if (expected_outcomes[$].status == spq_pkg::ST_FULL) overflows++;
    if (expected_outcomes[$].status == spq_pkg::ST_EMPTY) underflows++;
    @(negedge clk);
  endtask

  function automatic request_t random_record(logic [2:0] f);
    request_t r;
    r.func = f;
    r.pid = 8'($urandom);
    // Narrow key ranges now and then so that ties exercise sort stability.
    r.burst = ($urandom_range(0, 2) == 0) ? 16'($urandom_range(0, 3)) : 16'($urandom);
    r.prio = ($urandom_range(0, 2) == 0) ? 8'($urandom_range(0, 3)) : 8'($urandom);
    r.start = 16'($urandom);
    r.finish = 16'($urandom);
    return r;
  endfunction

  // Receiver: random stalls, plus a long hold-off when asked.
  initial begin
    outcome_t got;
    outcome_t want;
    int stall;
    forever begin
      @(negedge clk);
      stall = 0;
      if ($urandom_range(0, 3) == 0) stall = $urandom_range(0, 17);
      if (hold_off) begin
        stall = stall + 400;
        hold_off = 1'b0;
      end
      if (stall > 0) begin
        m_axis_tready <= 1'b0;
        repeat (stall) @(negedge clk);
      end
      m_axis_tready <= 1'b1;
      do @(posedge clk); while (!m_axis_tvalid);
      got = m_axis_tdata[72:0];
      if (expected_outcomes.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result %h", got);
      end else begin
        want = expected_outcomes.pop_front();
        if (got !== want) begin
          mismatches++;
          if (mismatches <= 10) begin
            $display("mismatch: expected v%0d id%0d b%0d p%0d s%0d f%0d e%0d n%0d st%0d",
                     want.valid, want.pid, want.burst, want.prio, want.start, want.finish,
                     want.empty, want.total, want.status);
            $display("          got      v%0d id%0d b%0d p%0d s%0d f%0d e%0d n%0d st%0d",
                     got.valid, got.pid, got.burst, got.prio, got.start, got.finish,
                     got.empty, got.total, got.status);
          end
        end
      end
    end
  end

  task automatic test_directed();
    request_t r;
    send_request(random_record(spq_pkg::FN_POP), 0);
    send_request(random_record(spq_pkg::FN_SORT_BURST), 0);
    r = '{spq_pkg::FN_PUSH_REAR, 8'hFF, 16'hFFFF, 8'hFF, 16'hFFFF, 16'hFFFF};
    send_request(r, 0);
    send_request(random_record(spq_pkg::FN_SORT_PRIO_DN), 0);
    r = '{spq_pkg::FN_PUSH_FRONT, 8'h00, 16'h0000, 8'h00, 16'h0000, 16'h0000};
    send_request(r, 1);
    for (int i = 0; i < 15; i++)
      send_request(random_record(i[0] ? spq_pkg::FN_PUSH_FRONT : spq_pkg::FN_PUSH_REAR), 0);
    send_request(random_record(spq_pkg::FN_SORT_BURST), 0);
    send_request(random_record(spq_pkg::FN_SORT_PRIO_UP), 0);
    send_request(random_record(spq_pkg::FN_SORT_PRIO_DN), 0);
    send_request(random_record(3'd6), 0);
    send_request(random_record(3'd7), 0);
  endtask

  task automatic test_backpressure();
    hold_off = 1'b1;
    for (int i = 0; i < 12; i++) send_request(random_record(spq_pkg::FN_POP), 0);
  endtask

  task automatic test_random(int count);
    logic [2:0] f;
    int pick;
    for (int i = 0; i < count; i++) begin
      pick = $urandom_range(0, 99);
      if (pick < 30) f = spq_pkg::FN_PUSH_REAR;
      else if (pick < 50) f = spq_pkg::FN_PUSH_FRONT;
      else if (pick < 80) f = spq_pkg::FN_POP;
      else if (pick < 97) f = 3'($urandom_range(3, 5));
      else f = 3'($urandom_range(6, 7));
      send_request(random_record(f), ($urandom_range(0, 4) == 0) ? $urandom_range(0, 17) : 0);
    end
  endtask

  initial begin
    int waited;
    repeat (7) @(negedge clk);
    rst <= 1'b0;
    test_directed();
    test_backpressure();
    test_random(1800);
    s_axis_tvalid <= 1'b0;
    waited = 0;
    while (expected_outcomes.size() != 0 && waited < 100000) begin
      @(negedge clk);
      waited++;
    end
    repeat (600) @(negedge clk);
    $display("Sent %0d requests: %0d records popped, %0d sorts, %0d overflows, %0d underflows.",
             requests_sent, records_popped, sorts_sent, overflows, underflows);
    if (mismatches == 0 && expected_outcomes.size() == 0) begin
      $display("status: pass");
    end else begin
      $display("%0d mismatches, %0d results missing", mismatches, expected_outcomes.size());
      $display("status: fail");
    end
    $finish;
  end

  initial begin
    #50ms;
    $display("timeout");
    $display("status: fail");
    $finish;
  end
endmodule
